/* rtl/swa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package swa_pkg;

  localparam int unsigned IdW   = 16;
  localparam int unsigned SampW = 16;
  localparam int unsigned TsW   = 32;

  // search token handed from cell to cell
  typedef struct packed {
    logic           vld;
    logic           found;
    logic [IdW-1:0] sid;
  } tok_t;

  // table load, broadcast to every cell
  typedef struct packed {
    logic           we;
    logic [IdW-1:0] sid;
    logic [IdW-1:0] room;
  } ld_t;

endpackage

`default_nettype wire

/* rtl/swa_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module swa_cell
  import swa_pkg::*;
#(
  parameter int unsigned MAX_SENSORS = 16,
  parameter int unsigned WINDOW      = 8,
  parameter int unsigned IDX         = 0
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic [$clog2(MAX_SENSORS+1)-1:0]        count_i,
  input  wire ld_t                                     ld_i,
  input  wire logic [((MAX_SENSORS>1)?$clog2(MAX_SENSORS):1)-1:0] ld_idx_i,
  input  wire logic                                    upd_we_i,
  input  wire logic [((MAX_SENSORS>1)?$clog2(MAX_SENSORS):1)-1:0] upd_idx_i,
  input  wire logic [((WINDOW>1)?$clog2(WINDOW):1)-1:0] upd_slot_i,
  input  wire logic [$clog2(WINDOW+1)-1:0]             upd_fill_i,
  input  wire logic signed [17+$clog2(WINDOW)-1:0]     upd_sum_i,
  input  wire logic [TsW-1:0]                          upd_ts_i,
  input  wire tok_t                                    tok_i,
  input  wire logic [((MAX_SENSORS>1)?$clog2(MAX_SENSORS):1)-1:0] hit_idx_i,
  input  wire logic [((WINDOW>1)?$clog2(WINDOW):1)-1:0] hit_slot_i,
  input  wire logic [$clog2(WINDOW+1)-1:0]             hit_fill_i,
  input  wire logic signed [17+$clog2(WINDOW)-1:0]     hit_sum_i,
  output tok_t                                         tok_o,
  output logic [((MAX_SENSORS>1)?$clog2(MAX_SENSORS):1)-1:0] hit_idx_o,
  output logic [((WINDOW>1)?$clog2(WINDOW):1)-1:0]     hit_slot_o,
  output logic [$clog2(WINDOW+1)-1:0]                  hit_fill_o,
  output logic signed [17+$clog2(WINDOW)-1:0]          hit_sum_o
);

  localparam int unsigned IDX_W  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SENSORS + 1);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned ACC_W  = 17 + $clog2(WINDOW);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MyCnt = CNT_W'(IDX);

  logic [IdW-1:0]          id_q;
  logic [IdW-1:0]          room_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [FILL_W-1:0]       fill_q;
  logic signed [ACC_W-1:0] sum_q;
  logic [TsW-1:0]          ts_q;

  tok_t                    tok_d, tok_q;
  logic [IDX_W-1:0]        idx_d, idx_q;
  logic [SLOT_W-1:0]       slot_d, slotp_q;
  logic [FILL_W-1:0]       fill_d, fillp_q;
  logic signed [ACC_W-1:0] sum_d, sump_q;

  logic used, hit;

  assign used = (MyCnt < count_i);
  // only the first matching entry claims the token
  assign hit  = tok_i.vld && !tok_i.found && used && (id_q == tok_i.sid);

  always_comb begin
    tok_d       = tok_i;
    tok_d.found = tok_i.found | hit;
    idx_d       = hit ? MyIdx  : hit_idx_i;
    slot_d      = hit ? slot_q : hit_slot_i;
    fill_d      = hit ? fill_q : hit_fill_i;
    sum_d       = hit ? sum_q  : hit_sum_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    slotp_q <= slot_d;
    fillp_q <= fill_d;
    sump_q  <= sum_d;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.we && (ld_idx_i == MyIdx)) begin
      id_q   <= ld_i.sid;
      room_q <= ld_i.room;
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (upd_we_i && (upd_idx_i == MyIdx)) begin
      slot_q <= upd_slot_i;
      fill_q <= upd_fill_i;
      sum_q  <= upd_sum_i;
      ts_q   <= upd_ts_i;
    end
  end

  assign tok_o      = tok_q;
  assign hit_idx_o  = idx_q;
  assign hit_slot_o = slotp_q;
  assign hit_fill_o = fillp_q;
  assign hit_sum_o  = sump_q;

endmodule

`default_nettype wire

/* rtl/swa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module swa_ctrl
  import swa_pkg::*;
#(
  parameter int unsigned MAX_SENSORS = 16,
  parameter int unsigned WINDOW      = 8
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  input  wire logic [79:0]                             s_axis_tdata,
  input  wire logic                                    s_axis_tuser,
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  output logic [39:0]                                  m_axis_tdata,
  input  wire logic signed [15:0]                      max_temp_i,
  input  wire logic signed [15:0]                      min_temp_i,
  output logic [$clog2(MAX_SENSORS+1)-1:0]             count_o,
  output ld_t                                          ld_o,
  output logic [((MAX_SENSORS>1)?$clog2(MAX_SENSORS):1)-1:0] ld_idx_o,
  output logic                                         upd_we_o,
  output logic [((MAX_SENSORS>1)?$clog2(MAX_SENSORS):1)-1:0] upd_idx_o,
  output logic [((WINDOW>1)?$clog2(WINDOW):1)-1:0]     upd_slot_o,
  output logic [$clog2(WINDOW+1)-1:0]                  upd_fill_o,
  output logic signed [17+$clog2(WINDOW)-1:0]          upd_sum_o,
  output logic [TsW-1:0]                               upd_ts_o,
  output tok_t                                         tok_o,
  input  wire tok_t                                    tail_tok_i,
  input  wire logic [((MAX_SENSORS>1)?$clog2(MAX_SENSORS):1)-1:0] tail_idx_i,
  input  wire logic [((WINDOW>1)?$clog2(WINDOW):1)-1:0] tail_slot_i,
  input  wire logic [$clog2(WINDOW+1)-1:0]             tail_fill_i,
  input  wire logic signed [17+$clog2(WINDOW)-1:0]     tail_sum_i
);

  localparam int unsigned IDX_W   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_SENSORS + 1);
  localparam int unsigned SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W  = $clog2(WINDOW + 1);
  localparam int unsigned ACC_W   = 17 + $clog2(WINDOW);
  localparam int unsigned DEPTH   = MAX_SENSORS * WINDOW;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // reciprocal of WINDOW, exact for every reachable window sum
  localparam int unsigned SH      = ACC_W + 7;
  localparam int unsigned RECIP_W = SH + 1;
  localparam longint unsigned RecipL = ((64'd1 << SH) + WINDOW - 1) / WINDOW;
  localparam int unsigned PROD_W  = ACC_W + RECIP_W;

  localparam logic [RECIP_W-1:0]      Recip   = RECIP_W'(RecipL);
  localparam logic [CNT_W-1:0]        MaxCnt  = CNT_W'(MAX_SENSORS);
  localparam logic [FILL_W-1:0]       WinFill = FILL_W'(WINDOW);
  localparam logic [SLOT_W-1:0]       LastSlt = SLOT_W'(WINDOW - 1);
  localparam logic [ADDR_W-1:0]       WinAddr = ADDR_W'(WINDOW);
  localparam logic signed [ACC_W-1:0] WinS    = ACC_W'(WINDOW);

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HOT     = 3'd1,
    ST_COLD    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_MEAS = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_READ   = 5'b00100,
    S_DIV    = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e st_d, st_q;
  logic [CNT_W-1:0] count_q;

  logic [IdW-1:0]          sid_q;
  logic [SampW-1:0]        samp_q;
  logic [TsW-1:0]          ts_q;
  logic [IDX_W-1:0]        idx_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [FILL_W-1:0]       fill_q;
  logic signed [ACC_W-1:0] sum_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [SampW-1:0]        rd_q;
  status_e                 res_status_q;
  logic                    res_avgv_q;
  logic                    neg_q;
  logic [PROD_W-1:0]       prod_q;

  logic                    out_vld_q;
  logic [IdW-1:0]          out_sid_q;
  status_e                 out_status_q;
  logic [15:0]             out_avg_q;
  logic                    out_avgv_q;

  logic [SampW-1:0] win_mem [DEPTH];

  logic                    in_acc, table_full, out_load;
  logic [IdW-1:0]          in_sid, in_room;
  logic [SampW-1:0]        in_samp;
  logic [TsW-1:0]          in_ts;
  logic [ADDR_W-1:0]       addr_c;
  logic                    win_full;
  logic signed [ACC_W-1:0] old_ext, samp_ext, new_sum;
  logic [FILL_W-1:0]       new_fill;
  logic [SLOT_W-1:0]       new_slot;
  logic signed [ACC_W-1:0] max_ext, min_ext, hi_thr, lo_thr;
  logic [ACC_W-1:0]        mag;
  logic [15:0]             quot, avg_c;
  status_e                 cmp_status;

  assign in_sid  = s_axis_tdata[15:0];
  assign in_room = s_axis_tdata[31:16];
  assign in_samp = s_axis_tdata[47:32];
  assign in_ts   = s_axis_tdata[79:48];

  assign s_axis_tready = (st_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign table_full    = (count_q == MaxCnt);
  assign out_load      = (st_q == S_DONE) && (!out_vld_q || m_axis_tready);

  // load goes straight into the addressed cell on the accepting edge
  assign ld_o.we   = in_acc && (op_e'(s_axis_tuser) == OP_LOAD) && !table_full;
  assign ld_o.sid  = in_sid;
  assign ld_o.room = in_room;
  assign ld_idx_o  = IDX_W'(count_q);
  assign count_o   = count_q;

  assign tok_o.vld   = in_acc && (op_e'(s_axis_tuser) == OP_MEAS);
  assign tok_o.found = 1'b0;
  assign tok_o.sid   = in_sid;

  assign addr_c = ADDR_W'(tail_idx_i) * WinAddr + ADDR_W'(tail_slot_i);

  // ring window update: drop the oldest sample once the window is full
  assign win_full = (fill_q == WinFill);
  assign old_ext  = win_full ? {{(ACC_W-SampW){rd_q[SampW-1]}}, rd_q} : '0;
  assign samp_ext = {{(ACC_W-SampW){samp_q[SampW-1]}}, samp_q};
  assign new_sum  = sum_q - old_ext + samp_ext;
  assign new_fill = win_full ? fill_q : fill_q + 1'b1;
  assign new_slot = (slot_q == LastSlt) ? '0 : slot_q + 1'b1;

  assign upd_we_o   = (st_q == S_READ);
  assign upd_idx_o  = idx_q;
  assign upd_slot_o = new_slot;
  assign upd_fill_o = new_fill;
  assign upd_sum_o  = new_sum;
  assign upd_ts_o   = ts_q;

  assign max_ext = {{(ACC_W-16){max_temp_i[15]}}, max_temp_i};
  assign min_ext = {{(ACC_W-16){min_temp_i[15]}}, min_temp_i};
  assign hi_thr  = max_ext * WinS;
  assign lo_thr  = min_ext * WinS;

  always_comb begin
    if (!res_avgv_q) begin
      cmp_status = ST_OK;
    end else if (sum_q > hi_thr) begin
      cmp_status = ST_HOT;
    end else if (sum_q < lo_thr) begin
      cmp_status = ST_COLD;
    end else begin
      cmp_status = ST_OK;
    end
  end

  assign mag   = sum_q[ACC_W-1] ? ACC_W'(-sum_q) : ACC_W'(sum_q);
  assign quot  = prod_q[SH +: 16];
  assign avg_c = !res_avgv_q ? 16'd0 : (neg_q ? 16'd0 - quot : quot);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          st_d = (op_e'(s_axis_tuser) == OP_LOAD) ? S_DONE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (tail_tok_i.vld) begin
          st_d = tail_tok_i.found ? S_READ : S_DONE;
        end
      end
      S_READ:  st_d = S_DIV;
      S_DIV:   st_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ld_o.we) begin
        count_q <= count_q + 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sid_q        <= in_sid;
      samp_q       <= in_samp;
      ts_q         <= in_ts;
      res_avgv_q   <= 1'b0;
      res_status_q <= ((op_e'(s_axis_tuser) == OP_LOAD) && table_full) ? ST_FULL : ST_OK;
    end
    if ((st_q == S_SEARCH) && tail_tok_i.vld) begin
      idx_q  <= tail_idx_i;
      slot_q <= tail_slot_i;
      fill_q <= tail_fill_i;
      sum_q  <= tail_sum_i;
      addr_q <= addr_c;
      if (!tail_tok_i.found) begin
        res_status_q <= ST_UNKNOWN;
      end
    end
    if (st_q == S_READ) begin
      sum_q      <= new_sum;
      res_avgv_q <= (new_fill == WinFill);
    end
    if (st_q == S_DIV) begin
      prod_q       <= PROD_W'(mag) * PROD_W'(Recip);
      neg_q        <= sum_q[ACC_W-1];
      res_status_q <= cmp_status;
    end
    if (out_load) begin
      out_sid_q    <= sid_q;
      out_status_q <= res_status_q;
      out_avg_q    <= avg_c;
      out_avgv_q   <= res_avgv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_READ) begin
      win_mem[addr_q] <= samp_q;
    end
    rd_q <= win_mem[addr_c];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_avgv_q, out_avg_q, out_status_q, out_sid_q};

endmodule

`default_nettype wire

/* rtl/sensor_window_average_alarm_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Per-sensor moving average with a temperature alarm.
// The s_axis channel takes one item per transaction: tuser = 0 loads a
// sensor/room pair into the next free table slot, tuser = 1 is a sample.
// Every transaction gives exactly one m_axis transaction carrying the sensor
// ID, a status code, the window average and its valid flag.
// A sample's ID search walks a row of MAX_SENSORS cells, one cell a cycle;
// then come the read-modify-write of the window memory (S_READ), the
// reciprocal multiply for the average together with the threshold compare
// (S_DIV), and S_DONE, which loads the result into the output register. A
// load goes straight to S_DONE. One item is in flight at a time and the next
// transaction is accepted in the cycle after the result is loaded. The
// output register lets an item be accepted while the previous result still
// waits; if the receiver stalls, the next result holds in its last step
// and s_axis_tready stays low until it can move on. Thresholds are written
// through cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so only while
// idle, as the block itself does not enforce it. Reset empties the table
// and sets the limits to 20.0 and 10.0 degrees; no clearing pass is needed.

module sensor_window_average_alarm_core
  import swa_pkg::*;
#(
  parameter int unsigned MAX_SENSORS = 16,
  parameter int unsigned WINDOW      = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // sensor_id[15:0], room_id[31:16], sample_value[47:32], timestamp[79:48]
  input  wire logic [79:0] s_axis_tdata,
  // op[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result_sensor[15:0], status[18:16], average[34:19], average_valid[35]
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned IDX_W  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SENSORS + 1);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned ACC_W  = 17 + $clog2(WINDOW);

  localparam logic signed [15:0] MaxTempRst = 16'sd5120;
  localparam logic signed [15:0] MinTempRst = 16'sd2560;

  typedef enum logic [0:0] {
    REG_MAX_TEMP = 1'b0,
    REG_MIN_TEMP = 1'b1
  } cfg_reg_e;

  logic signed [15:0] max_temp_q, min_temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_temp_q <= MaxTempRst;
      min_temp_q <= MinTempRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MAX_TEMP: max_temp_q <= cfg_data_i;
        REG_MIN_TEMP: min_temp_q <= cfg_data_i;
        default:      max_temp_q <= max_temp_q;
      endcase
    end
  end

  logic [CNT_W-1:0]        count;
  ld_t                     ld;
  logic [IDX_W-1:0]        ld_idx;
  logic                    upd_we;
  logic [IDX_W-1:0]        upd_idx;
  logic [SLOT_W-1:0]       upd_slot;
  logic [FILL_W-1:0]       upd_fill;
  logic signed [ACC_W-1:0] upd_sum;
  logic [TsW-1:0]          upd_ts;

  tok_t                    tok  [MAX_SENSORS+1];
  logic [IDX_W-1:0]        lidx [MAX_SENSORS+1];
  logic [SLOT_W-1:0]       lslt [MAX_SENSORS+1];
  logic [FILL_W-1:0]       lfil [MAX_SENSORS+1];
  logic signed [ACC_W-1:0] lsum [MAX_SENSORS+1];

  assign lidx[0] = '0;
  assign lslt[0] = '0;
  assign lfil[0] = '0;
  assign lsum[0] = '0;

  swa_ctrl #(
    .MAX_SENSORS (MAX_SENSORS),
    .WINDOW      (WINDOW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .max_temp_i    (max_temp_q),
    .min_temp_i    (min_temp_q),
    .count_o       (count),
    .ld_o          (ld),
    .ld_idx_o      (ld_idx),
    .upd_we_o      (upd_we),
    .upd_idx_o     (upd_idx),
    .upd_slot_o    (upd_slot),
    .upd_fill_o    (upd_fill),
    .upd_sum_o     (upd_sum),
    .upd_ts_o      (upd_ts),
    .tok_o         (tok[0]),
    .tail_tok_i    (tok[MAX_SENSORS]),
    .tail_idx_i    (lidx[MAX_SENSORS]),
    .tail_slot_i   (lslt[MAX_SENSORS]),
    .tail_fill_i   (lfil[MAX_SENSORS]),
    .tail_sum_i    (lsum[MAX_SENSORS])
  );

  for (genvar g = 0; g < MAX_SENSORS; g++) begin : g_cell
    swa_cell #(
      .MAX_SENSORS (MAX_SENSORS),
      .WINDOW      (WINDOW),
      .IDX         (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .count_i    (count),
      .ld_i       (ld),
      .ld_idx_i   (ld_idx),
      .upd_we_i   (upd_we),
      .upd_idx_i  (upd_idx),
      .upd_slot_i (upd_slot),
      .upd_fill_i (upd_fill),
      .upd_sum_i  (upd_sum),
      .upd_ts_i   (upd_ts),
      .tok_i      (tok[g]),
      .hit_idx_i  (lidx[g]),
      .hit_slot_i (lslt[g]),
      .hit_fill_i (lfil[g]),
      .hit_sum_i  (lsum[g]),
      .tok_o      (tok[g+1]),
      .hit_idx_o  (lidx[g+1]),
      .hit_slot_o (lslt[g+1]),
      .hit_fill_o (lfil[g+1]),
      .hit_sum_o  (lsum[g+1])
    );
  end

endmodule

`default_nettype wire

/* dv/swa_tb_pkg.sv */
`timescale 1ns / 1ps

package swa_tb_pkg;

  import swa_pkg::*;

  localparam int NumSensors = 16;
  localparam int WindowLen  = 8;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HOT     = 3'd1,
    ST_COLD    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  localparam logic REG_MAX_TEMP = 1'b0;
  localparam logic REG_MIN_TEMP = 1'b1;

  // s_axis_tdata layout, lowest field last
  typedef struct packed {
    logic [TsW-1:0]          stamp;
    logic signed [SampW-1:0] sample;
    logic [IdW-1:0]          room;
    logic [IdW-1:0]          sid;
  } item_t;

  // m_axis_tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]              pad;
    logic                    valid;
    logic signed [SampW-1:0] avg;
    status_e                 status;
    logic [IdW-1:0]          sid;
  } result_t;

endpackage

/* dv/sensor_alarm_monitor.sv */
`timescale 1ns / 1ps

module sensor_alarm_monitor
  import swa_pkg::*;
  import swa_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          pending_o,
  output int          fail_o,
  output int          checked_o,
  output int          averaged_o,
  output int          alarms_o
);

  // mirror of the sensor table and the sample windows
  int                      n_entries;
  logic [IdW-1:0]          known_id   [NumSensors];
  logic [IdW-1:0]          known_room [NumSensors];
  int                      ring_pos   [NumSensors];
  int                      ring_fill  [NumSensors];
  logic signed [SampW-1:0] ring       [NumSensors][WindowLen];
  logic [TsW-1:0]          seen_at    [NumSensors];
  int                      hot_limit;
  int                      cold_limit;

  result_t                 expected_results[$];

  function automatic result_t window_alarm(op_e op, item_t it);
    result_t r;
    int      hit;
    int      sum;
    r     = '0;
    r.sid = it.sid;
    if (op == OP_LOAD) begin
      if (n_entries >= NumSensors) begin
        r.status = ST_FULL;
      end else begin
        known_id[n_entries]   = it.sid;
        known_room[n_entries] = it.room;
        ring_pos[n_entries]   = 0;
        ring_fill[n_entries]  = 0;
        n_entries++;
      end
    end else begin
      hit = -1;
      // first match wins, later duplicates stay hidden
      for (int i = 0; i < n_entries; i++) begin
        if (hit < 0 && known_id[i] == it.sid) hit = i;
      end
      if (hit < 0) begin
        r.status = ST_UNKNOWN;
      end else begin
        ring[hit][ring_pos[hit]] = it.sample;
        ring_pos[hit] = (ring_pos[hit] + 1) % WindowLen;
        if (ring_fill[hit] < WindowLen) ring_fill[hit]++;
        seen_at[hit] = it.stamp;
        if (ring_fill[hit] == WindowLen) begin
          sum = 0;
          for (int k = 0; k < WindowLen; k++) sum += ring[hit][k];
          r.avg   = SampW'(sum / WindowLen);
          r.valid = 1'b1;
          // compare the exact sum so truncation cannot move the status
          if (sum > hot_limit * WindowLen) r.status = ST_HOT;
          else if (sum < cold_limit * WindowLen) r.status = ST_COLD;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      n_entries  = 0;
      hot_limit  = 5120;
      cold_limit = 2560;
      for (int i = 0; i < NumSensors; i++) begin
        ring_pos[i]  = 0;
        ring_fill[i] = 0;
      end
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_TEMP: hot_limit  = int'($signed(cfg_data_i));
          REG_MIN_TEMP: cold_limit = int'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: sensor %h status %0d average %h valid %b",
                   $time, got.sid, got.status, got.avg, got.valid);
          fail_o++;
        end else begin
          want = expected_results.pop_front();
          checked_o++;
          if (got.sid !== want.sid || got.status !== want.status ||
              got.avg !== want.avg || got.valid !== want.valid) begin
            $display("%0t: mismatch: expected sensor %h status %0d average %h valid %b",
                     $time, want.sid, want.status, want.avg, want.valid);
            $display("%0t:           actual   sensor %h status %0d average %h valid %b",
                     $time, got.sid, got.status, got.avg, got.valid);
            fail_o++;
          end
          if (want.valid) averaged_o++;
          if (want.status == ST_HOT || want.status == ST_COLD) alarms_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(window_alarm(op_e'(s_axis_tuser), item_t'(s_axis_tdata)));
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

/* dv/tb_sensor_window_average_alarm_core.sv */
`timescale 1ns / 1ps

module tb_sensor_window_average_alarm_core;

  import swa_pkg::*;
  import swa_tb_pkg::*;

  localparam int NumPhases    = 8;
  localparam int PhaseItems   = 250;
  localparam int SettleCycles = 2 * (NumSensors + 4);

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [79:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [15:0] cfg_data_i    = '0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [39:0] m_axis_tdata;

  int pending, fails, checked, averaged, alarms;
  int gap_pct   = 0;
  int stall_pct = 0;
  int n_loads   = 0;
  int n_samples = 0;
  int n_settings = 0;
  logic [IdW-1:0] loaded_ids[$];

  sensor_window_average_alarm_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  sensor_alarm_monitor u_alarm_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .fail_o        (fails),
    .checked_o     (checked),
    .averaged_o    (averaged),
    .alarms_o      (alarms)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #8ms;
    $display("tb_sensor_window_average_alarm_core failed");
    $finish;
  end

  task automatic send_item(op_e op, logic [IdW-1:0] sid, logic [IdW-1:0] room,
                           logic [SampW-1:0] sample, logic [TsW-1:0] stamp);
    item_t it;
    it.sid    = sid;
    it.room   = room;
    it.sample = sample;
    it.stamp  = stamp;
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= it;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OP_LOAD) begin
      n_loads++;
      if (loaded_ids.size() < NumSensors) loaded_ids.push_back(sid);
    end else begin
      n_samples++;
    end
  endtask

  // hold the sender until every transaction has returned
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [15:0] hot, logic [15:0] cold);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MAX_TEMP;
    cfg_data_i <= hot;
    @(posedge clk_i);
    cfg_idx_i  <= REG_MIN_TEMP;
    cfg_data_i <= cold;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    n_settings++;
  endtask

  task automatic random_item(int lo_lim, int hi_lim);
    int             pick;
    int             val;
    logic [IdW-1:0] sid;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0, 1:    val = $signed(16'($urandom));
      2, 3:    val = ($urandom_range(0, 1) ? hi_lim : lo_lim) + int'($urandom_range(0, 2)) - 1;
      default: val = lo_lim - 1024 + int'($urandom_range(0, hi_lim - lo_lim + 2048));
    endcase
    if (val > 32767) val = 32767;
    if (val < -32768) val = -32768;
    if (pick < 8 || loaded_ids.size() == 0) begin
      send_item(OP_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    end else begin
      // mostly known sensors, some stray IDs
      if (pick < 18) sid = 16'($urandom);
      else sid = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
      send_item(OP_SAMPLE, sid, 16'($urandom), 16'(val), $urandom);
    end
  endtask

  initial begin
    int max_set[NumPhases];
    int min_set[NumPhases];
    int lo_lim;
    int hi_lim;
    max_set = '{32767, -32768, 0, 5120, 0, -256, 0, 5120};
    min_set = '{-32768, 32767, 0, 2560, 0, -512, 0, 2560};
    for (int p = 4; p < NumPhases; p += 2) begin
      min_set[p] = int'($urandom_range(0, 6000)) - 3000;
      max_set[p] = min_set[p] + int'($urandom_range(0, 3000));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, then edge IDs with a duplicate, then fill both windows
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0100, 32'h0000_0000);
    send_item(OP_LOAD,   16'h0000, 16'hffff, 16'h0000, 32'hffff_ffff);
    send_item(OP_LOAD,   16'hffff, 16'h0000, 16'hffff, 32'h0000_0000);
    send_item(OP_LOAD,   16'h0000, 16'h1234, 16'h0000, 32'h0000_0001);
    send_item(OP_SAMPLE, 16'h8001, 16'h0000, 16'h0000, 32'h0000_0002);
    for (int i = 0; i < WindowLen; i++) begin
      send_item(OP_SAMPLE, 16'hffff, 16'h0000, 16'h7fff, 32'hffff_ffff);
    end
    for (int i = 0; i < WindowLen; i++) begin
      send_item(OP_SAMPLE, 16'h0000, 16'hffff, 16'h8000, 32'(i));
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      set_limits(16'(max_set[p]), 16'(min_set[p]));
      lo_lim = (max_set[p] < min_set[p]) ? max_set[p] : min_set[p];
      hi_lim = (max_set[p] < min_set[p]) ? min_set[p] : max_set[p];
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 86; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 86; end
        default: begin
          gap_pct   = 37;
          stall_pct = 37;
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 1 && n == PhaseItems / 2) drain();
        random_item(lo_lim, hi_lim);
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Run covered %0d loads and %0d samples across %0d limit settings.",
             n_loads, n_samples, n_settings);
    $display("%0d results compared, %0d with a window average, %0d hot or cold alarms.",
             checked, averaged, alarms);
    if (fails == 0) begin
      $display("tb_sensor_window_average_alarm_core passed");
    end else begin
      $display("tb_sensor_window_average_alarm_core failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/swa_pkg.sv
rtl/swa_cell.sv
rtl/swa_ctrl.sv
rtl/sensor_window_average_alarm_core.sv
dv/swa_tb_pkg.sv
dv/sensor_alarm_monitor.sv
dv/tb_sensor_window_average_alarm_core.sv
